### design/rms_pkg.sv
// ----------------------------------------------------------------------------
// Range-minimum segment tree package
// Shared sizes, item kinds and beat types of the range-minimum segment tree.
// ----------------------------------------------------------------------------
package rms_pkg;

   localparam int MAX_LEAVES = 1024;
   localparam int NODE_DEPTH = 2 * MAX_LEAVES;
   localparam int NODE_AW    = $clog2(NODE_DEPTH);
   localparam int IDX_W      = NODE_AW + 1;
   localparam int COUNT_W    = 11;
   localparam int POS_W      = 10;
   localparam int DATA_W     = 32;

   localparam logic [COUNT_W-1:0]       LEAF_COUNT_RESET = COUNT_W'(MAX_LEAVES);
   localparam logic signed [DATA_W-1:0] INT_MAX          = 32'sh7FFF_FFFF;

   typedef enum logic [1:0] {
      KIND_LOAD   = 2'd0,
      KIND_BUILD  = 2'd1,
      KIND_UPDATE = 2'd2,
      KIND_QUERY  = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type                  kind;
      logic [POS_W-1:0]          position;
      logic [COUNT_W-1:0]        query_end;
      logic signed [DATA_W-1:0]  value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0]  minimum;
      logic                      range_empty;
   } rsp_type;

endpackage

### design/rms_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One read or write address per cycle; read data is registered.
// ----------------------------------------------------------------------------
module rms_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

### design/range_min_segment_tree_core.sv
// ----------------------------------------------------------------------------
// Range-minimum segment tree core
// Bottom-up segment tree over signed 32-bit leaves with load, build, point
// update and half-open range-minimum query, all on one single-port node RAM.
// ----------------------------------------------------------------------------
// A beat is accepted when start is high and busy is low; a query returns one
// result beat on rsp_valid for a single cycle, and the receiver cannot stall it.
// A load does not leave idle, and an empty query answers in the cycle after accept.
// Every other item is paced by the single-port node RAM and one shared min
// comparator: a build reads both children and writes the parent per internal
// node, an update writes its leaf, then reads the sibling and writes the parent
// per level, and a query checks and folds its low and high ends per level.
// The node RAM is not cleared at reset; nodes must be loaded and built first.
// ----------------------------------------------------------------------------
module range_min_segment_tree_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  rms_pkg::req_type               req_data,
   output logic                           rsp_valid,
   output rms_pkg::rsp_type               rsp_data,
   input  logic                           csr_write_en,
   input  logic [rms_pkg::COUNT_W-1:0]    csr_write_data
);

   typedef enum logic [8:0] {
      ST_IDLE    = 9'b000000001,
      ST_B_RD0   = 9'b000000010,
      ST_B_RD1   = 9'b000000100,
      ST_B_WR    = 9'b000001000,
      ST_U_RD    = 9'b000010000,
      ST_U_WR    = 9'b000100000,
      ST_Q_CHK   = 9'b001000000,
      ST_Q_HI    = 9'b010000000,
      ST_Q_SHIFT = 9'b100000000
   } state_type;

   state_type                            state_ff, state_in;
   logic [rms_pkg::COUNT_W-1:0]          n_ff, n_in;
   logic [rms_pkg::IDX_W-1:0]            idx_ff, idx_in;
   logic [rms_pkg::IDX_W-1:0]            hi_ff, hi_in;
   logic signed [rms_pkg::DATA_W-1:0]    acc_ff, acc_in;
   logic                                 lo_pend_ff, lo_pend_in;
   logic                                 hi_pend_ff, hi_pend_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   rms_pkg::rsp_type                     rsp_data_ff, rsp_data_in;

   logic                                 ram_we;
   logic [rms_pkg::NODE_AW-1:0]          ram_addr;
   logic signed [rms_pkg::DATA_W-1:0]    ram_wdata;
   logic signed [rms_pkg::DATA_W-1:0]    ram_rdata;

   logic signed [rms_pkg::DATA_W-1:0]    min_val;
   logic                                 accept;
   logic [rms_pkg::IDX_W-1:0]            leaf_idx;
   logic [rms_pkg::COUNT_W-1:0]          q_end;
   logic                                 pos_in_range;
   logic [rms_pkg::IDX_W-1:0]            parent_idx;
   logic [rms_pkg::IDX_W-1:0]            hi_dec;

   rms_ram #(
      .WIDTH(rms_pkg::DATA_W),
      .DEPTH(rms_pkg::NODE_DEPTH)
   ) u_node_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // Shared compare unit: all folding goes through this one signed minimum.
   assign min_val = (acc_ff <= ram_rdata) ? acc_ff : ram_rdata;

   assign busy         = (state_ff != ST_IDLE);
   assign accept       = start && !busy;
   assign leaf_idx     = rms_pkg::IDX_W'(req_data.position) + rms_pkg::IDX_W'(n_ff);
   assign pos_in_range = (rms_pkg::COUNT_W'(req_data.position) < n_ff);
   assign q_end        = (req_data.query_end > n_ff) ? n_ff : req_data.query_end;
   assign parent_idx   = {1'b0, idx_ff[rms_pkg::IDX_W-1:1]};
   assign hi_dec       = hi_ff - rms_pkg::IDX_W'(1);

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      idx_in       = idx_ff;
      hi_in        = hi_ff;
      acc_in       = acc_ff;
      lo_pend_in   = lo_pend_ff;
      hi_pend_in   = hi_pend_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      ram_we       = 1'b0;
      ram_addr     = idx_ff[rms_pkg::NODE_AW-1:0];
      ram_wdata    = min_val;

      if (csr_write_en) begin
         if (csr_write_data == '0) begin
            n_in = rms_pkg::COUNT_W'(1);
         end else if (csr_write_data > rms_pkg::LEAF_COUNT_RESET) begin
            n_in = rms_pkg::LEAF_COUNT_RESET;
         end else begin
            n_in = csr_write_data;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_data.kind)
                  rms_pkg::KIND_LOAD: begin
                     ram_we    = pos_in_range;
                     ram_addr  = leaf_idx[rms_pkg::NODE_AW-1:0];
                     ram_wdata = req_data.value;
                  end
                  rms_pkg::KIND_BUILD: begin
                     idx_in = rms_pkg::IDX_W'(n_ff) - rms_pkg::IDX_W'(1);
                     if (n_ff > rms_pkg::COUNT_W'(1)) begin
                        state_in = ST_B_RD0;
                     end
                  end
                  rms_pkg::KIND_UPDATE: begin
                     ram_we    = pos_in_range;
                     ram_addr  = leaf_idx[rms_pkg::NODE_AW-1:0];
                     ram_wdata = req_data.value;
                     idx_in    = leaf_idx;
                     acc_in    = req_data.value;
                     if (pos_in_range && (leaf_idx > rms_pkg::IDX_W'(1))) begin
                        state_in = ST_U_RD;
                     end
                  end
                  rms_pkg::KIND_QUERY: begin
                     if (rms_pkg::COUNT_W'(req_data.position) >= q_end) begin
                        rsp_valid_in            = 1'b1;
                        rsp_data_in.minimum     = rms_pkg::INT_MAX;
                        rsp_data_in.range_empty = 1'b1;
                     end else begin
                        idx_in   = leaf_idx;
                        hi_in    = rms_pkg::IDX_W'(q_end) + rms_pkg::IDX_W'(n_ff);
                        acc_in   = rms_pkg::INT_MAX;
                        state_in = ST_Q_CHK;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_B_RD0: begin
            ram_addr = {idx_ff[rms_pkg::NODE_AW-2:0], 1'b0};
            state_in = ST_B_RD1;
         end
         ST_B_RD1: begin
            ram_addr = {idx_ff[rms_pkg::NODE_AW-2:0], 1'b1};
            acc_in   = ram_rdata;
            state_in = ST_B_WR;
         end
         ST_B_WR: begin
            ram_we   = 1'b1;
            ram_addr = idx_ff[rms_pkg::NODE_AW-1:0];
            idx_in   = idx_ff - rms_pkg::IDX_W'(1);
            state_in = (idx_ff == rms_pkg::IDX_W'(1)) ? ST_IDLE : ST_B_RD0;
         end
         ST_U_RD: begin
            ram_addr = {idx_ff[rms_pkg::NODE_AW-1:1], ~idx_ff[0]};
            state_in = ST_U_WR;
         end
         ST_U_WR: begin
            ram_we   = 1'b1;
            ram_addr = parent_idx[rms_pkg::NODE_AW-1:0];
            acc_in   = min_val;
            idx_in   = parent_idx;
            state_in = (parent_idx > rms_pkg::IDX_W'(1)) ? ST_U_RD : ST_IDLE;
         end
         ST_Q_CHK: begin
            if (idx_ff >= hi_ff) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.minimum     = acc_ff;
               rsp_data_in.range_empty = 1'b0;
               state_in                = ST_IDLE;
            end else begin
               lo_pend_in = idx_ff[0];
               if (idx_ff[0]) begin
                  idx_in = idx_ff + rms_pkg::IDX_W'(1);
               end
               state_in = ST_Q_HI;
            end
         end
         ST_Q_HI: begin
            if (lo_pend_ff) begin
               acc_in = min_val;
            end
            hi_pend_in = hi_ff[0];
            ram_addr   = hi_dec[rms_pkg::NODE_AW-1:0];
            if (hi_ff[0]) begin
               hi_in = hi_dec;
            end
            state_in = ST_Q_SHIFT;
         end
         ST_Q_SHIFT: begin
            if (hi_pend_ff) begin
               acc_in = min_val;
            end
            idx_in   = {1'b0, idx_ff[rms_pkg::IDX_W-1:1]};
            hi_in    = {1'b0, hi_ff[rms_pkg::IDX_W-1:1]};
            state_in = ST_Q_CHK;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         n_ff         <= rms_pkg::LEAF_COUNT_RESET;
         rsp_valid_ff <= 1'b0;
         lo_pend_ff   <= 1'b0;
         hi_pend_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         n_ff         <= n_in;
         rsp_valid_ff <= rsp_valid_in;
         lo_pend_ff   <= lo_pend_in;
         hi_pend_ff   <= hi_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      hi_ff       <= hi_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### design/rms_checker.sv
// ----------------------------------------------------------------------------
// Range-minimum segment tree port checker
// Watches the top-level ports and flags result beats that break the contract.
// ----------------------------------------------------------------------------
module rms_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic                           busy,
   input  rms_pkg::req_type               req_data,
   input  logic                           rsp_valid,
   input  rms_pkg::rsp_type               rsp_data,
   input  logic                           csr_write_en,
   input  logic [rms_pkg::COUNT_W-1:0]    csr_write_data
);

   logic accept;

   assign accept = start && !busy;

   // A result beat only follows an accepted beat or work in progress.
   a_rsp_has_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(busy) || $past(start)))
      else $error("result beat without a preceding request");

   // An empty range always reports the largest value.
   a_empty_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.range_empty) |-> (rsp_data.minimum == rms_pkg::INT_MAX))
      else $error("empty range reported with a wrong minimum");

   // A load finishes at once and produces no result beat.
   a_load_quick: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_data.kind == rms_pkg::KIND_LOAD)) |=> (!busy && !rsp_valid))
      else $error("load kept the block busy or produced a result");

   // A query either answers next cycle or keeps the block busy.
   a_query_pending: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_data.kind == rms_pkg::KIND_QUERY)) |=> (busy || rsp_valid))
      else $error("query was dropped");

endmodule

bind range_min_segment_tree_core rms_checker u_rms_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .req_data       (req_data),
   .rsp_valid      (rsp_valid),
   .rsp_data       (rsp_data),
   .csr_write_en   (csr_write_en),
   .csr_write_data (csr_write_data)
);

### bench/range_min_segment_tree_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range-minimum segment tree core testbench
// Drives loads, builds, point updates and range queries through the command
// port at several leaf counts and checks every query result against a local
// model of the node store, first with directed corner cases, then at random.
// ----------------------------------------------------------------------------
module range_min_segment_tree_core_tb;

   import rms_pkg::*;

   logic           clock = 1'b0;
   logic           reset = 1'b1;
   logic           start = 1'b0;
   logic           busy;
   req_type        req_data = '0;
   logic           rsp_valid;
   rsp_type        rsp_data;
   logic           csr_write_en = 1'b0;
   logic [COUNT_W-1:0] csr_write_data = '0;

   logic signed [DATA_W-1:0] node_model [0:NODE_DEPTH-1];
   logic [COUNT_W-1:0]       leaf_count_model = LEAF_COUNT_RESET;
   rsp_type                  pending_minima [$];
   rsp_type                  oldest_minimum;

   int unsigned idle_pct = 0;
   int unsigned failures = 0;
   int unsigned loads_sent = 0;
   int unsigned builds_sent = 0;
   int unsigned updates_sent = 0;
   int unsigned queries_sent = 0;
   int unsigned empties_seen = 0;
   int unsigned results_checked = 0;
   int unsigned counts_written = 0;

   range_min_segment_tree_core uut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned leaves_in_use();
      if (leaf_count_model == 0) return 1;
      if (leaf_count_model > MAX_LEAVES) return MAX_LEAVES;
      return leaf_count_model;
   endfunction

   function automatic logic signed [DATA_W-1:0] lesser(input logic signed [DATA_W-1:0] a,
                                                       input logic signed [DATA_W-1:0] b);
      return (b < a) ? b : a;
   endfunction

   function automatic bit segment_tree_step(input req_type item, output rsp_type result);
      int unsigned n;
      int unsigned k;
      int unsigned lo;
      int unsigned hi;
      int unsigned qe;
      logic signed [DATA_W-1:0] best;
      n = leaves_in_use();
      result = '0;
      case (item.kind)
         KIND_LOAD: begin
            if (item.position < n) node_model[n + item.position] = item.value;
            return 1'b0;
         end
         KIND_BUILD: begin
            for (k = n - 1; k > 0; k--)
               node_model[k] = lesser(node_model[2 * k], node_model[2 * k + 1]);
            return 1'b0;
         end
         KIND_UPDATE: begin
            if (item.position >= n) return 1'b0;
            k = n + item.position;
            node_model[k] = item.value;
            for (; k > 1; k >>= 1)
               node_model[k >> 1] = lesser(node_model[k], node_model[k ^ 1]);
            return 1'b0;
         end
         KIND_QUERY: begin
            qe = item.query_end;
            if (qe > n) qe = n;
            if (item.position >= qe) begin
               result.minimum = INT_MAX;
               result.range_empty = 1'b1;
               return 1'b1;
            end
            best = INT_MAX;
            lo = item.position + n;
            hi = qe + n;
            for (; lo < hi; lo >>= 1, hi >>= 1) begin
               if (lo & 1) begin
                  best = lesser(best, node_model[lo]);
                  lo++;
               end
               if (hi & 1) begin
                  hi--;
                  best = lesser(best, node_model[hi]);
               end
            end
            result.minimum = best;
            result.range_empty = 1'b0;
            return 1'b1;
         end
      endcase
      return 1'b0;
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_minima.size() == 0) begin
            $error("unexpected result beat: minimum %0d, range_empty %0b",
                   rsp_data.minimum, rsp_data.range_empty);
            failures++;
         end else begin
            oldest_minimum = pending_minima.pop_front();
            results_checked++;
            if (oldest_minimum.range_empty) empties_seen++;
            if (rsp_data.minimum !== oldest_minimum.minimum) begin
               $error("minimum: expected %0d, actual %0d",
                      oldest_minimum.minimum, rsp_data.minimum);
               failures++;
            end
            if (rsp_data.range_empty !== oldest_minimum.range_empty) begin
               $error("range_empty: expected %0b, actual %0b",
                      oldest_minimum.range_empty, rsp_data.range_empty);
               failures++;
            end
         end
      end
   end

   function automatic req_type make_item(input kind_type kind, input int unsigned pos,
                                         input int unsigned qend,
                                         input logic signed [DATA_W-1:0] value);
      req_type item;
      item.kind = kind;
      item.position = POS_W'(pos);
      item.query_end = COUNT_W'(qend);
      item.value = value;
      return item;
   endfunction

   function automatic logic signed [DATA_W-1:0] random_value();
      case ($urandom_range(15))
         0: return 32'sh8000_0000;
         1: return INT_MAX;
         2: return -32'sd1;
         3: return 32'sd0;
         4, 5: return $signed(32'($urandom_range(6))) - 32'sd3;
         default: return $signed($urandom);
      endcase
   endfunction

   task automatic send_item(input req_type item);
      rsp_type result;
      int unsigned gap;
      start <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy !== 1'b0);
      if (segment_tree_step(item, result)) pending_minima.push_back(result);
      case (item.kind)
         KIND_LOAD:   loads_sent++;
         KIND_BUILD:  builds_sent++;
         KIND_UPDATE: updates_sent++;
         KIND_QUERY:  queries_sent++;
      endcase
      if ($urandom_range(99) < idle_pct) begin
         gap = ($urandom_range(3) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 6);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic load_leaf(input int unsigned pos, input logic signed [DATA_W-1:0] value);
      send_item(make_item(KIND_LOAD, pos, $urandom_range(2047), value));
   endtask

   task automatic update_leaf(input int unsigned pos, input logic signed [DATA_W-1:0] value);
      send_item(make_item(KIND_UPDATE, pos, $urandom_range(2047), value));
   endtask

   task automatic build_tree();
      send_item(make_item(KIND_BUILD, $urandom_range(1023), $urandom_range(2047), $urandom));
   endtask

   task automatic ask_min(input int unsigned pos, input int unsigned qend);
      send_item(make_item(KIND_QUERY, pos, qend, $urandom));
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      while (pending_minima.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
   endtask

   task automatic set_leaf_count(input int unsigned count);
      wait_idle();
      csr_write_en <= 1'b1;
      csr_write_data <= COUNT_W'(count);
      @(posedge clock);
      csr_write_en <= 1'b0;
      leaf_count_model = COUNT_W'(count);
      counts_written++;
   endtask

   task automatic fill_tree();
      int unsigned i;
      for (i = 0; i < leaves_in_use(); i++) load_leaf(i, random_value());
      build_tree();
   endtask

   task automatic test_full_width();
      fill_tree();
      ask_min(0, 1024);
      ask_min(0, 2047);
      ask_min(1023, 1024);
      ask_min(512, 513);
      update_leaf(1023, 32'sh8000_0000);
      ask_min(1000, 2047);
      update_leaf(0, INT_MAX);
      ask_min(0, 1);
      ask_min(1023, 0);
      set_leaf_count(2047);
      ask_min(0, 1024);
      ask_min(341, 1022);
   endtask

   task automatic test_corner_cases();
      set_leaf_count(5);
      fill_tree();
      load_leaf(0, INT_MAX);
      load_leaf(2, 32'sh8000_0000);
      load_leaf(5, -32'sd9);
      load_leaf(1023, -32'sd9);
      build_tree();
      ask_min(0, 5);
      ask_min(0, 2);
      ask_min(2, 3);
      ask_min(3, 2047);
      ask_min(5, 5);
      ask_min(4, 4);
      ask_min(3, 1);
      ask_min(1023, 2047);
      update_leaf(4, 32'sh8000_0000);
      update_leaf(7, -32'sd1);
      update_leaf(1023, -32'sd1);
      ask_min(3, 5);
      update_leaf(2, INT_MAX);
      ask_min(0, 5);
      set_leaf_count(0);
      fill_tree();
      ask_min(0, 1);
      ask_min(0, 0);
      ask_min(0, 2047);
      update_leaf(0, -32'sd5);
      update_leaf(1, 32'sd5);
      ask_min(0, 1);
      set_leaf_count(1);
      fill_tree();
      ask_min(0, 1);
      set_leaf_count(2);
      fill_tree();
      update_leaf(1, 32'sh8000_0000);
      ask_min(0, 2);
   endtask

   task automatic random_op();
      int unsigned n;
      int unsigned lo;
      int unsigned i;
      n = leaves_in_use();
      lo = $urandom_range(0, n - 1);
      case ($urandom_range(99)) inside
         [0:44]: begin
            case ($urandom_range(9))
               0: ask_min($urandom_range(1023), $urandom_range(2047));
               1: ask_min(lo, $urandom_range(0, lo));
               2: ask_min(lo, $urandom_range(n, 2047));
               default: ask_min(lo, $urandom_range(lo + 1, n));
            endcase
         end
         [45:74]: begin
            if (n < MAX_LEAVES && $urandom_range(7) == 0)
               update_leaf($urandom_range(n, 1023), random_value());
            else
               update_leaf(lo, random_value());
         end
         [75:87]: begin
            for (i = $urandom_range(1, 3); i > 0; i--)
               load_leaf($urandom_range(0, n - 1), random_value());
            build_tree();
         end
         [88:93]: build_tree();
         default: begin
            if (n < MAX_LEAVES) load_leaf($urandom_range(n, 1023), random_value());
            else ask_min(lo, $urandom_range(lo + 1, n));
         end
      endcase
   endtask

   task automatic test_random(input int unsigned phases, input int unsigned ops);
      int unsigned p;
      int unsigned i;
      for (p = 0; p < phases; p++) begin
         case ($urandom_range(15))
            0: set_leaf_count(0);
            1: set_leaf_count(1);
            2: set_leaf_count(2);
            3: set_leaf_count($urandom_range(1024, 2047));
            default: set_leaf_count($urandom_range(3, 48));
         endcase
         fill_tree();
         for (i = 0; i < ops; i++) random_op();
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      idle_pct = 13;
      test_full_width();
      test_corner_cases();
      test_random(5, 50);
      idle_pct = 48;
      test_random(5, 50);
      idle_pct = 0;
      test_random(5, 50);
      wait_idle();
      repeat (10) @(posedge clock);
      $display("Checked %0d query results (%0d empty ranges) after %0d loads, %0d builds",
               results_checked, empties_seen, loads_sent, builds_sent);
      $display("and %0d point updates, over %0d leaf count settings including 0 and 2047.",
               updates_sent, counts_written);
      if (failures == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule
